/* hdl/bspu_pkg.sv */
`default_nettype none

package bspu_pkg;

    // largest block edge that the expander supports
    localparam int MAX_BLOCK = 8;

    // field widths
    localparam int CMD_W  = 2;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 31;
    localparam int SIZE_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // request commands
    localparam logic [CMD_W-1:0] CMD_ROW   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINAL = 2'd2;

    // write kinds
    localparam logic KIND_ROW_PTR = 1'b0;
    localparam logic KIND_COL_IDX = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_BLOCK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINTER_BASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_BASE    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IN_W-1:0]  block_row;
        logic [IN_W-1:0]  row_start;
        logic [IN_W-1:0]  row_end;
        logic [IN_W-1:0]  entry_pos;
        logic [IN_W-1:0]  block_col;
        logic [IN_W-1:0]  total_len;
    } t_bspu_req;

    typedef struct packed {
        logic             kind;
        logic [OUT_W-1:0] address;
        logic [OUT_W-1:0] value;
        logic             last;
    } t_bspu_rsp;

endpackage

`default_nettype wire

/* hdl/block_sparse_pattern_unroll_top.sv */
// first write command of a request passes stage 1, stage 2, expander and output register
// throughput: one write command per cycle from a single expander counter pair unless
//   the output is stalled; a row request yields R commands, an entry R*C, a final one
// requests are taken every cycle while each expands to one command and the output moves
// reset: synchronous, active low; pipeline emptied, block sizes 1, bases 0
`default_nettype none

module block_sparse_pattern_unroll_top #(
    parameter int MAX_BLOCK = bspu_pkg::MAX_BLOCK
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [bspu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bspu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request channel
    input  wire logic                               i_req_valid,
    output logic                                    o_req_ready,
    input  wire bspu_pkg::t_bspu_req                i_req,
    // write command channel
    output logic                                    o_rsp_valid,
    input  wire logic                               i_rsp_ready,
    output bspu_pkg::t_bspu_rsp                     o_rsp
);

    localparam int SW = $clog2(MAX_BLOCK + 1);
    localparam int BW = 2 * SW;
    localparam int OW = bspu_pkg::OUT_W;
    localparam int IW = bspu_pkg::IN_W;
    localparam int CW = bspu_pkg::CMD_W;

    // block size with zero read as one and large values limited
    function automatic logic [SW-1:0] clamp_size(input logic [bspu_pkg::SIZE_W-1:0] s);
        logic [SW-1:0] res;
        if (s == '0) begin
            res = SW'(1);
        end else if (32'(s) > 32'(MAX_BLOCK)) begin
            res = SW'(MAX_BLOCK);
        end else begin
            res = SW'(s);
        end
        return res;
    endfunction

    // configuration registers
    logic [bspu_pkg::SIZE_W-1:0] r_row_bs;
    logic [bspu_pkg::SIZE_W-1:0] r_col_bs;
    logic                        r_ptr_base;
    logic                        r_col_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bs   <= bspu_pkg::SIZE_W'(1);
            r_col_bs   <= bspu_pkg::SIZE_W'(1);
            r_ptr_base <= 1'b0;
            r_col_base <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bspu_pkg::REG_ROW_BLOCK_SIZE: r_row_bs   <= i_cfg_data;
                bspu_pkg::REG_COL_BLOCK_SIZE: r_col_bs   <= i_cfg_data;
                bspu_pkg::REG_POINTER_BASE:   r_ptr_base <= i_cfg_data[0];
                bspu_pkg::REG_COLUMN_BASE:    r_col_base <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic          r_s1_valid;
    logic [CW-1:0] r_s1_cmd;
    logic [IW-1:0] r_s1_brow;
    logic [IW-1:0] r_s1_tlen;
    logic [OW-1:0] r_s1_d_base;
    logic [OW-1:0] r_s1_d_span;
    logic [OW-1:0] r_s1_d_off;
    logic [OW-1:0] r_s1_d_col;
    logic [SW-1:0] r_s1_r;
    logic [SW-1:0] r_s1_c;
    logic [BW-1:0] r_s1_b;

    logic          r_s2_valid;
    logic [CW-1:0] r_s2_cmd;
    logic [OW-1:0] r_s2_arow;
    logic [OW-1:0] r_s2_base;
    logic [OW-1:0] r_s2_span;
    logic [OW-1:0] r_s2_off;
    logic [OW-1:0] r_s2_col0;
    logic [OW-1:0] r_s2_tval;
    logic [SW-1:0] r_s2_r;
    logic [SW-1:0] r_s2_c;

    logic          r_e_valid;
    logic [CW-1:0] r_e_cmd;
    logic [OW-1:0] r_e_arow;
    logic [OW-1:0] r_e_rowp;
    logic [OW-1:0] r_e_span;
    logic [OW-1:0] r_e_col0;
    logic [OW-1:0] r_e_tval;
    logic [SW-1:0] r_e_r;
    logic [SW-1:0] r_e_c;
    logic [SW-1:0] r_e_k;
    logic [SW-1:0] r_e_j;

    logic                r_out_valid;
    bspu_pkg::t_bspu_rsp r_out;

    // handshake chain
    logic out_free;
    logic e_fire;
    logic e_last;
    logic e_ready;
    logic s2_ready;
    logic s1_ready;
    logic req_take;
    logic req_known;

    logic k_end;
    logic j_end;

    assign out_free  = !r_out_valid || i_rsp_ready;
    assign k_end     = (r_e_k == (r_e_r - SW'(1)));
    assign j_end     = (r_e_j == (r_e_c - SW'(1)));
    assign e_fire    = r_e_valid && out_free;
    assign e_ready   = !r_e_valid || (e_fire && e_last);
    assign s2_ready  = !r_s2_valid || e_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;
    assign req_take  = i_req_valid && s1_ready;
    assign req_known = (i_req.cmd == bspu_pkg::CMD_ROW) ||
                       (i_req.cmd == bspu_pkg::CMD_ENTRY) ||
                       (i_req.cmd == bspu_pkg::CMD_FINAL);

    assign o_req_ready = s1_ready;

    // last command of the current request
    always_comb begin
        case (r_e_cmd)
            bspu_pkg::CMD_ROW:   e_last = k_end;
            bspu_pkg::CMD_ENTRY: e_last = k_end && j_end;
            default:             e_last = 1'b1;
        endcase
    end

    // stage 1: clamp sizes and take base differences
    logic [SW-1:0] n_s1_r;
    logic [SW-1:0] n_s1_c;

    assign n_s1_r = clamp_size(r_row_bs);
    assign n_s1_c = clamp_size(r_col_bs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= req_take && req_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_s1_cmd    <= i_req.cmd;
            r_s1_brow   <= i_req.block_row;
            r_s1_tlen   <= i_req.total_len;
            r_s1_d_base <= OW'(i_req.row_start) - OW'(r_ptr_base);
            r_s1_d_span <= OW'(i_req.row_end) - OW'(i_req.row_start);
            r_s1_d_off  <= OW'(i_req.entry_pos) - OW'(i_req.row_start);
            r_s1_d_col  <= OW'(i_req.block_col) - OW'(r_col_base);
            r_s1_r      <= n_s1_r;
            r_s1_c      <= n_s1_c;
            r_s1_b      <= BW'(n_s1_r) * BW'(n_s1_c);
        end
    end

    // stage 2: scale by block sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_ready) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_arow <= OW'(OW'(r_s1_brow) * OW'(r_s1_r));
            r_s2_base <= OW'(r_s1_d_base * OW'(r_s1_b));
            r_s2_span <= OW'(r_s1_d_span * OW'(r_s1_c));
            r_s2_off  <= OW'(r_s1_d_off * OW'(r_s1_c));
            r_s2_col0 <= OW'(r_s1_d_col * OW'(r_s1_c));
            r_s2_tval <= OW'(OW'(r_s1_tlen) * OW'(r_s1_b));
            r_s2_r    <= r_s1_r;
            r_s2_c    <= r_s1_c;
        end
    end

    // expander: walks row offsets and column offsets, one command a cycle unless the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (e_ready) begin
            r_e_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_ready && r_s2_valid) begin
            r_e_cmd  <= r_s2_cmd;
            r_e_arow <= r_s2_arow;
            r_e_rowp <= (r_s2_cmd == bspu_pkg::CMD_ENTRY) ? r_s2_base + r_s2_off
                                                           : r_s2_base;
            r_e_span <= r_s2_span;
            r_e_col0 <= r_s2_col0;
            r_e_tval <= r_s2_tval;
            r_e_r    <= r_s2_r;
            r_e_c    <= r_s2_c;
            r_e_k    <= '0;
            r_e_j    <= '0;
        end else if (e_fire && !e_last) begin
            if (r_e_cmd == bspu_pkg::CMD_ROW || j_end) begin
                r_e_k    <= r_e_k + SW'(1);
                r_e_j    <= '0;
                r_e_rowp <= r_e_rowp + r_e_span;
            end else begin
                r_e_j <= r_e_j + SW'(1);
            end
        end
    end

    // next write command
    bspu_pkg::t_bspu_rsp n_out;

    always_comb begin
        n_out.last = e_last;
        case (r_e_cmd)
            bspu_pkg::CMD_ROW: begin
                n_out.kind    = bspu_pkg::KIND_ROW_PTR;
                n_out.address = r_e_arow + OW'(r_e_k);
                n_out.value   = r_e_rowp;
            end
            bspu_pkg::CMD_ENTRY: begin
                n_out.kind    = bspu_pkg::KIND_COL_IDX;
                n_out.address = r_e_rowp + OW'(r_e_j);
                n_out.value   = r_e_col0 + OW'(r_e_j);
            end
            default: begin
                n_out.kind    = bspu_pkg::KIND_ROW_PTR;
                n_out.address = r_e_arow;
                n_out.value   = r_e_tval;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_fire) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire
